FILE: rtl/fcst_pkg.sv
// Shared types and constants of the floor and ceiling span texturer.
`timescale 1ns / 1ps

package fcst_pkg;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned STORE_AW    = 12;
  localparam int unsigned DIVISOR_W   = 13;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam logic [22:0] HALF_MASK   = 23'h7F7F7F;

  localparam logic [1:0] OP_LOAD_FLOOR = 2'd0;
  localparam logic [1:0] OP_LOAD_CEIL  = 2'd1;
  localparam logic [1:0] OP_RENDER     = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X         = 3'd0,
    CFG_POS_Y         = 3'd1,
    CFG_DIR_X         = 3'd2,
    CFG_DIR_Y         = 3'd3,
    CFG_PLANE_X       = 3'd4,
    CFG_PLANE_Y       = 3'd5,
    CFG_SCREEN_WIDTH  = 3'd6,
    CFG_SCREEN_HEIGHT = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_LOAD_FLOOR,
    CMD_LOAD_CEIL,
    CMD_PIXEL
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] row;
    logic [11:0] column;
    logic [11:0] texel_index;
    logic [23:0] texel_color;
  } in_req_t;

  typedef struct packed {
    logic [11:0] floor_row;
    logic [11:0] ceiling_row;
    logic [11:0] out_column;
    logic [22:0] floor_color;
    logic [22:0] ceiling_color;
    logic        row_last;
  } out_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] plane_x;
    logic signed [31:0] plane_y;
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        setup;
    logic [11:0] row;
    logic [11:0] column;
    logic [11:0] ceiling_row;
    logic        row_last;
    logic [11:0] texel_index;
    logic [23:0] texel_color;
  } cmd_t;

endpackage

FILE: rtl/floor_ceiling_span_texturer.sv
// Top level of the floor and ceiling span texturer.
`timescale 1ns / 1ps

// Floor and ceiling caster for a raycaster, signed fixed point with FRAC_BITS
// fractional bits. Requests either load a texel into the floor or ceiling store
// (4096 x 24 bits each, contents undefined until loaded) or render one floor
// pixel; a render request yields one result with the floor row, the mirrored
// ceiling row, the column and both texels halved. Render requests for rows at
// or above the horizon, and unknown ops, are dropped without a result. The front
// end classifies requests into a four-entry command queue; the back end runs
// them one at a time. A load is written to its store as it leaves the queue; a
// pixel passes through the states S_PIX and S_OUT. Column 0 of a row first runs
// the row setup on one shared bit-serial divider and one 32x32 multiplier: three
// divisions of ND quotient bits, ND = max(12+FRAC_BITS, 64-FRAC_BITS), then
// multiplies. Requests keep entering while the queue has room and a result waits
// in the output register. Write configuration only while the block is idle.

module floor_ceiling_span_texturer #(
  parameter int unsigned TEX_W     = 64,
  parameter int unsigned TEX_H     = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  fcst_pkg::in_req_t                in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output fcst_pkg::out_req_t               out_req_o,
  input  logic                             cfg_we_i,
  input  logic [fcst_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                      cfg_data_i
);

  fcst_pkg::cfg_t cfg_q;
  fcst_pkg::cmd_t push_cmd, head_cmd;
  logic           push, pop, q_full, q_empty;

  // hold configuration; reset gives the default camera and a 640x480 screen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x         <= 32'sd0;
      cfg_q.pos_y         <= 32'sd0;
      cfg_q.dir_x         <= -32'sd65536;
      cfg_q.dir_y         <= 32'sd0;
      cfg_q.plane_x       <= 32'sd0;
      cfg_q.plane_y       <= 32'sd43253;
      cfg_q.screen_width  <= 13'd640;
      cfg_q.screen_height <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fcst_pkg::CFG_POS_X:         cfg_q.pos_x         <= cfg_data_i;
        fcst_pkg::CFG_POS_Y:         cfg_q.pos_y         <= cfg_data_i;
        fcst_pkg::CFG_DIR_X:         cfg_q.dir_x         <= cfg_data_i;
        fcst_pkg::CFG_DIR_Y:         cfg_q.dir_y         <= cfg_data_i;
        fcst_pkg::CFG_PLANE_X:       cfg_q.plane_x       <= cfg_data_i;
        fcst_pkg::CFG_PLANE_Y:       cfg_q.plane_y       <= cfg_data_i;
        fcst_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[12:0];
        fcst_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // classify each request and drop those that give no result
  fcst_front u_front (
    .in_req_i   (in_req_i),
    .in_valid_i (in_valid_i),
    .q_full_i   (q_full),
    .cfg_i      (cfg_q),
    .in_stall_o (in_stall_o),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  fcst_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // row setup, texel stores and the registered result
  fcst_back #(
    .TEX_W     (TEX_W),
    .TEX_H     (TEX_H),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_head_i    (head_cmd),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

FILE: rtl/fcst_front.sv
// Front end: classifies incoming requests into queue commands.
`timescale 1ns / 1ps

module fcst_front (
  input  fcst_pkg::in_req_t in_req_i,
  input  logic              in_valid_i,
  input  logic              q_full_i,
  input  fcst_pkg::cfg_t    cfg_i,
  output logic              in_stall_o,
  output logic              q_push_o,
  output fcst_pkg::cmd_t    q_cmd_o
);

  logic [11:0] half;
  logic [12:0] width;
  logic        keep;

  assign half  = cfg_i.screen_height[12:1];
  assign width = (cfg_i.screen_width == 13'd0) ? 13'd1 : cfg_i.screen_width;

  always_comb begin
    keep             = 1'b0;
    q_cmd_o.kind     = fcst_pkg::CMD_PIXEL;
    q_cmd_o.setup    = (in_req_i.column == 12'd0);
    q_cmd_o.row      = in_req_i.row;
    q_cmd_o.column   = in_req_i.column;
    q_cmd_o.ceiling_row = 12'(cfg_i.screen_height - {1'b0, in_req_i.row} - 13'd1);
    q_cmd_o.row_last = ({1'b0, in_req_i.column} == (width - 13'd1));
    q_cmd_o.texel_index = in_req_i.texel_index;
    q_cmd_o.texel_color = in_req_i.texel_color;
    unique case (in_req_i.op)
      fcst_pkg::OP_LOAD_FLOOR: begin
        keep         = 1'b1;
        q_cmd_o.kind = fcst_pkg::CMD_LOAD_FLOOR;
      end
      fcst_pkg::OP_LOAD_CEIL: begin
        keep         = 1'b1;
        q_cmd_o.kind = fcst_pkg::CMD_LOAD_CEIL;
      end
      fcst_pkg::OP_RENDER: begin
        // drop rows at or above the horizon
        keep = (in_req_i.row > half);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

FILE: rtl/fcst_queue.sv
// Command queue between front end and back end.
`timescale 1ns / 1ps

module fcst_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fcst_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output fcst_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PW = $clog2(fcst_pkg::QUEUE_DEPTH);

  fcst_pkg::cmd_t slots_q [fcst_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [PW:0]    cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(fcst_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop_i)  rd_q <= rd_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (PW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= push_cmd_i;
  end

endmodule

FILE: rtl/fcst_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fcst_div #(
  parameter int unsigned ND = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ND-1:0]                     dividend_i,
  input  logic [fcst_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic                              done_o,
  output logic [ND-1:0]                     quot_o
);

  localparam int unsigned DW = fcst_pkg::DIVISOR_W;
  localparam int unsigned CW = $clog2(ND + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, dvs_q, rem_nx;
  logic [ND-1:0] dq_q;
  logic [DW:0]   trial;
  logic          ge;

  assign trial  = {rem_q, dq_q[ND-1]};
  assign ge     = (trial >= {1'b0, dvs_q});
  assign rem_nx = ge ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ND);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      dq_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      dq_q  <= {dq_q[ND-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

FILE: rtl/fcst_back.sv
// Back end: row setup sequencer, texel stores and pixel output.
`timescale 1ns / 1ps

module fcst_back #(
  parameter int unsigned TEX_W     = 64,
  parameter int unsigned TEX_H     = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcst_pkg::cfg_t     cfg_i,
  input  logic               q_empty_i,
  input  fcst_pkg::cmd_t     q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fcst_pkg::out_req_t out_req_o
);

  localparam int unsigned ND  = ((12 + FRAC_BITS) > (64 - FRAC_BITS)) ?
                                (12 + FRAC_BITS) : (64 - FRAC_BITS);
  localparam int unsigned TCW = $clog2((TEX_W > TEX_H) ? TEX_W : TEX_H);
  localparam int unsigned PVW = FRAC_BITS + TCW + 1;
  localparam int unsigned AW  = fcst_pkg::STORE_AW;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_RD, S_MUL_DX, S_DIV_SX_GO, S_DIV_SX, S_MUL_DY, S_DIV_SY_GO,
    S_DIV_SY, S_MUL_LX, S_ACC_X, S_MUL_LY, S_ACC_Y, S_PIX, S_OUT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat_quot(input logic [ND-1:0] q, input logic neg);
    logic signed [31:0] r;
    if (neg) r = (q > ND'(64'h8000_0000)) ? 32'sh80000000 : -$signed(q[31:0]);
    else     r = (q >= ND'(64'h8000_0000)) ? 32'sh7FFFFFFF : $signed(q[31:0]);
    return r;
  endfunction

  function automatic logic [TCW-1:0] tex_coord(input logic signed [31:0] acc,
                                               input int unsigned size);
    logic [32:0]    mag;
    logic [PVW-1:0] pv;
    logic [TCW-1:0] q;
    mag = acc[31] ? (33'd0 - {1'b1, acc}) : {1'b0, acc};
    pv  = PVW'(mag[FRAC_BITS-1:0]) * PVW'(size);
    q   = TCW'(pv >> FRAC_BITS);
    q   = acc[31] ? (~q + TCW'(1)) : q;
    return q & TCW'(size - 1);
  endfunction

  state_e             state_q;
  fcst_pkg::cmd_t     cmd_q;
  logic [30:0]        rd_q;
  logic signed [63:0] prod_q;
  logic               neg_q;
  logic signed [31:0] step_x_q, step_y_q, acc_x_q, acc_y_q;
  logic signed [31:0] lx_q, ly_q, rx_q, ry_q, dx_q, dy_q;
  logic [23:0]        floor_rd_q, ceil_rd_q;
  logic               out_valid_q;
  fcst_pkg::out_req_t out_q;

  logic [23:0] floor_mem [fcst_pkg::STORE_DEPTH];
  logic [23:0] ceil_mem  [fcst_pkg::STORE_DEPTH];

  logic [12:0]        width, p_div;
  logic [11:0]        half;
  logic signed [31:0] mul_b, pos_sel;
  logic signed [63:0] mul_p, tsh_s, acc_sum;
  logic [63:0]        prod_mag, tsh_mag;
  logic               div_start, div_done;
  logic [ND-1:0]      div_dividend, div_quot;
  logic [12:0]        div_divisor;
  logic [TCW-1:0]     tx, ty;
  logic [31:0]        addr_w;
  logic               take, out_free;

  assign width = (cfg_i.screen_width == 13'd0) ? 13'd1 : cfg_i.screen_width;
  assign half  = cfg_i.screen_height[12:1];
  assign p_div = {1'b0, q_head_i.row} - {1'b0, half};
  assign take  = (state_q == S_IDLE) && !q_empty_i;
  assign q_pop_o = take;

  always_comb begin
    unique case (state_q)
      S_MUL_DX: mul_b = dx_q;
      S_MUL_DY: mul_b = dy_q;
      S_MUL_LX: mul_b = lx_q;
      default:  mul_b = ly_q;
    endcase
  end

  assign mul_p    = $signed({1'b0, rd_q}) * mul_b;
  assign prod_mag = prod_q[63] ? (~prod_q + 64'd1) : prod_q;
  assign tsh_mag  = prod_mag >> FRAC_BITS;
  assign tsh_s    = prod_q[63] ? -$signed(tsh_mag) : $signed(tsh_mag);
  assign pos_sel  = (state_q == S_ACC_X) ? cfg_i.pos_x : cfg_i.pos_y;
  assign acc_sum  = 64'(pos_sel) + tsh_s;

  assign div_start = (take && (q_head_i.kind == fcst_pkg::CMD_PIXEL) && q_head_i.setup)
                  || (state_q == S_DIV_SX_GO) || (state_q == S_DIV_SY_GO);
  assign div_dividend = (state_q == S_IDLE) ?
                        (ND'(cfg_i.screen_height) << (FRAC_BITS - 1)) : ND'(tsh_mag);
  assign div_divisor  = (state_q == S_IDLE) ? p_div : width;

  fcst_div #(.ND(ND)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign tx     = tex_coord(acc_x_q, TEX_W);
  assign ty     = tex_coord(acc_y_q, TEX_H);
  assign addr_w = 32'(TEX_W) * 32'(ty) + 32'(tx);
  assign out_free = !out_valid_q || !out_stall_i;

  // ray edges and span from configuration, two register stages
  always_ff @(posedge clk_i) begin
    lx_q <= sat32(64'(cfg_i.dir_x) - 64'(cfg_i.plane_x));
    rx_q <= sat32(64'(cfg_i.dir_x) + 64'(cfg_i.plane_x));
    ly_q <= sat32(64'(cfg_i.dir_y) - 64'(cfg_i.plane_y));
    ry_q <= sat32(64'(cfg_i.dir_y) + 64'(cfg_i.plane_y));
    dx_q <= sat32(64'(rx_q) - 64'(lx_q));
    dy_q <= sat32(64'(ry_q) - 64'(ly_q));
  end

  always_ff @(posedge clk_i) begin
    if (take && (q_head_i.kind == fcst_pkg::CMD_LOAD_FLOOR))
      floor_mem[q_head_i.texel_index] <= q_head_i.texel_color;
    if (take && (q_head_i.kind == fcst_pkg::CMD_LOAD_CEIL))
      ceil_mem[q_head_i.texel_index] <= q_head_i.texel_color;
    if (state_q == S_PIX) begin
      floor_rd_q <= floor_mem[addr_w[AW-1:0]];
      ceil_rd_q  <= ceil_mem[addr_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      rd_q        <= '0;
      prod_q      <= '0;
      neg_q       <= 1'b0;
      step_x_q    <= '0;
      step_y_q    <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (take && (q_head_i.kind == fcst_pkg::CMD_PIXEL)) begin
            cmd_q   <= q_head_i;
            state_q <= q_head_i.setup ? S_DIV_RD : S_PIX;
          end
        end
        S_DIV_RD: begin
          if (div_done) begin
            rd_q    <= (div_quot >= ND'(64'h8000_0000)) ? 31'h7FFFFFFF : div_quot[30:0];
            state_q <= S_MUL_DX;
          end
        end
        S_MUL_DX: begin
          prod_q  <= mul_p;
          state_q <= S_DIV_SX_GO;
        end
        S_DIV_SX_GO: begin
          neg_q   <= prod_q[63];
          state_q <= S_DIV_SX;
        end
        S_DIV_SX: begin
          if (div_done) begin
            step_x_q <= sat_quot(div_quot, neg_q);
            state_q  <= S_MUL_DY;
          end
        end
        S_MUL_DY: begin
          prod_q  <= mul_p;
          state_q <= S_DIV_SY_GO;
        end
        S_DIV_SY_GO: begin
          neg_q   <= prod_q[63];
          state_q <= S_DIV_SY;
        end
        S_DIV_SY: begin
          if (div_done) begin
            step_y_q <= sat_quot(div_quot, neg_q);
            state_q  <= S_MUL_LX;
          end
        end
        S_MUL_LX: begin
          prod_q  <= mul_p;
          state_q <= S_ACC_X;
        end
        S_ACC_X: begin
          acc_x_q <= sat32(acc_sum);
          state_q <= S_MUL_LY;
        end
        S_MUL_LY: begin
          prod_q  <= mul_p;
          state_q <= S_ACC_Y;
        end
        S_ACC_Y: begin
          acc_y_q <= sat32(acc_sum);
          state_q <= S_PIX;
        end
        S_PIX: begin
          acc_x_q <= acc_x_q + step_x_q;
          acc_y_q <= acc_y_q + step_y_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q         <= 1'b1;
            out_q.floor_row     <= cmd_q.row;
            out_q.ceiling_row   <= cmd_q.ceiling_row;
            out_q.out_column    <= cmd_q.column;
            out_q.floor_color   <= 23'(floor_rd_q >> 1) & fcst_pkg::HALF_MASK;
            out_q.ceiling_color <= 23'(ceil_rd_q >> 1) & fcst_pkg::HALF_MASK;
            out_q.row_last      <= cmd_q.row_last;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule
